// File: sv/ssm_pkg.sv
// Shared types and constants for the sensor staleness monitor.
// Holds the beat structs, the packet passed along the cell chain and the kind codes.
// No dependencies.
package ssm_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned EV_W         = $clog2(SENSOR_COUNT + 1);

  localparam logic [2:0] KIND_SAMPLE    = 3'd0;
  localparam logic [2:0] KIND_DEPTH     = 3'd1;
  localparam logic [2:0] KIND_DROP      = 3'd2;
  localparam logic [2:0] KIND_SUPERVISE = 3'd3;
  localparam logic [2:0] KIND_READ      = 3'd4;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_ID = 1'b1;

  localparam logic [31:0] THRESHOLD_RESET = 32'd1000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ID_W-1:0]    sensor_sel;
    logic [31:0]        sequence_number;
    logic [31:0]        time_ms;
    logic signed [31:0] sample_value;
    logic [31:0]        depth_level;
  } ssm_in_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        accepted_count;
    logic [31:0]        dropped_count;
    logic [31:0]        high_watermark;
    logic [31:0]        stale_event_count;
    logic               entry_seen;
    logic               entry_stale;
    logic [31:0]        entry_sequence;
    logic [31:0]        entry_time_ms;
    logic signed [31:0] entry_value;
  } ssm_out_t;

  // Command and collected results travelling one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [ID_W-1:0]    sensor_sel;
    logic [31:0]        sequence_number;
    logic [31:0]        time_ms;
    logic signed [31:0] sample_value;
    logic               rd_seen;
    logic               rd_stale;
    logic [31:0]        rd_sequence;
    logic [31:0]        rd_time_ms;
    logic signed [31:0] rd_value;
    logic [EV_W-1:0]    ev_cnt;
  } ssm_pkt_t;

endpackage

// File: sv/ssm_cell.sv
// One sensor entry of the staleness monitor chain.
// Acts on the packet passing through and hands it, registered, to the next cell.
// Depends on ssm_pkg.
module ssm_cell import ssm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] idx_i,
  input  logic [31:0]     thr_i,
  input  ssm_pkt_t        pkt_i,
  output ssm_pkt_t        pkt_o
);

  logic               seen_q, seen_d;
  logic               stale_q, stale_d;
  logic [31:0]        seq_q, seq_d;
  logic [31:0]        time_q, time_d;
  logic signed [31:0] value_q, value_d;
  ssm_pkt_t           pkt_q, pkt_d;
  logic               valid_q;
  logic               match;
  logic [31:0]        age;
  logic               now_stale;

  assign match     = (pkt_i.sensor_sel == idx_i);
  assign age       = pkt_i.time_ms - time_q;
  assign now_stale = (age > thr_i);

  always_comb begin
    seen_d  = seen_q;
    stale_d = stale_q;
    seq_d   = seq_q;
    time_d  = time_q;
    value_d = value_q;
    pkt_d   = pkt_i;
    if (pkt_i.valid) begin
      case (pkt_i.kind)
        KIND_SAMPLE: begin
          if (match) begin
            seen_d  = 1'b1;
            stale_d = 1'b0;
            seq_d   = pkt_i.sequence_number;
            time_d  = pkt_i.time_ms;
            value_d = pkt_i.sample_value;
          end
        end
        KIND_SUPERVISE: begin
          if (seen_q) begin
            stale_d = now_stale;
            if (now_stale && !stale_q) begin
              pkt_d.ev_cnt = pkt_i.ev_cnt + EV_W'(1);
            end
          end
        end
        KIND_READ: begin
          if (match) begin
            pkt_d.rd_seen     = seen_q;
            pkt_d.rd_stale    = stale_q;
            pkt_d.rd_sequence = seq_q;
            pkt_d.rd_time_ms  = time_q;
            pkt_d.rd_value    = value_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      stale_q <= 1'b0;
      seq_q   <= '0;
      time_q  <= '0;
      value_q <= '0;
      valid_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      stale_q <= stale_d;
      seq_q   <= seq_d;
      time_q  <= time_d;
      value_q <= value_d;
      valid_q <= pkt_d.valid;
    end
  end

  // Payload fields carry no reset; only the valid bit qualifies them.
  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  always_comb begin
    pkt_o       = pkt_q;
    pkt_o.valid = valid_q;
  end

endmodule

// File: sv/sensor_staleness_monitor_top.sv
// Top level of the sensor staleness monitor.
// Holds the global counters, the threshold register and the output stage around
// a chain of ssm_cell instances. Depends on ssm_pkg and ssm_cell.
//
// Usage: one input beat on in_valid_i/in_ready_o carries one command (sample,
// queue depth report, drop, supervise tick or sensor read), and each command
// gives exactly one result beat on out_valid_o/out_ready_i carrying the four
// global counters and, for a valid read, the addressed sensor's entry.
// The stale threshold is written through cfg_we_i/cfg_wdata_i while idle.
// Every command travels the whole chain of SENSOR_COUNT cells, one cell per
// cycle, so every sensor entry is visited by the same packet. The next input
// beat is taken only once the previous command has left the last cell, so
// only one command is in the chain at a time.
// A finished result waits in the output register while the next command is
// already taken. If a second result finishes while the receiver still stalls,
// it parks in a one-deep holding register and input stays blocked until the
// holding register drains.
// Reset clears all counters, all sensor entries and marks, and sets the
// threshold to 1000 ms; the block is ready as soon as reset is released.
module sensor_staleness_monitor_top import ssm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ssm_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ssm_out_t    out_data_o
);

  logic [31:0] thr_q;
  logic [31:0] acc_q, acc_d;
  logic [31:0] drop_q, drop_d;
  logic [31:0] peak_q, peak_d;
  logic [31:0] stev_q, stev_d;
  logic [31:0] depth_q;
  logic        busy_q;
  logic        out_valid_q;
  logic        pend_valid_q;
  ssm_out_t    out_q;
  ssm_out_t    pend_q;
  ssm_out_t    res;

  logic        in_accept;
  logic        out_take;
  logic        chain_done;
  logic        id_ok;
  ssm_pkt_t    head_pkt;
  ssm_pkt_t    chain [SENSOR_COUNT+1];
  ssm_pkt_t    last_pkt;
  logic [SENSOR_COUNT-1:0] chain_vld;

  assign in_ready_o = !busy_q && !pend_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // The command enters the first cell straight from the input beat.
  always_comb begin
    head_pkt                 = '0;
    head_pkt.valid           = in_accept;
    head_pkt.kind            = in_data_i.kind;
    head_pkt.sensor_sel      = in_data_i.sensor_sel;
    head_pkt.sequence_number = in_data_i.sequence_number;
    head_pkt.time_ms         = in_data_i.time_ms;
    head_pkt.sample_value    = in_data_i.sample_value;
  end

  assign chain[0] = head_pkt;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_cell
    ssm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (ID_W'(i)),
      .thr_i  (thr_q),
      .pkt_i  (chain[i]),
      .pkt_o  (chain[i+1])
    );
    assign chain_vld[i] = chain[i+1].valid;
  end

  assign last_pkt   = chain[SENSOR_COUNT];
  assign chain_done = last_pkt.valid;
  assign id_ok      = ({1'b0, last_pkt.sensor_sel} < (ID_W + 1)'(SENSOR_COUNT));

  // Global counters after the command that just left the chain.
  always_comb begin
    acc_d  = acc_q;
    drop_d = drop_q;
    peak_d = peak_q;
    stev_d = stev_q;
    case (last_pkt.kind)
      KIND_SAMPLE: begin
        if (id_ok) begin
          acc_d = acc_q + 32'd1;
        end
      end
      KIND_DEPTH: begin
        if (depth_q > peak_q) begin
          peak_d = depth_q;
        end
      end
      KIND_DROP: begin
        drop_d = drop_q + 32'd1;
      end
      KIND_SUPERVISE: begin
        stev_d = stev_q + 32'(last_pkt.ev_cnt);
      end
      default: begin
      end
    endcase
  end

  // Entry fields from the cells are zero unless a cell matched a read.
  always_comb begin
    res                   = '0;
    res.accepted_count    = acc_d;
    res.dropped_count     = drop_d;
    res.high_watermark    = peak_d;
    res.stale_event_count = stev_d;
    res.status            = STATUS_OK;
    if ((last_pkt.kind == KIND_SAMPLE || last_pkt.kind == KIND_READ) && !id_ok) begin
      res.status = STATUS_BAD_ID;
    end
    if (last_pkt.kind == KIND_READ) begin
      res.entry_seen     = last_pkt.rd_seen;
      res.entry_stale    = last_pkt.rd_stale;
      res.entry_sequence = last_pkt.rd_sequence;
      res.entry_time_ms  = last_pkt.rd_time_ms;
      res.entry_value    = last_pkt.rd_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESHOLD_RESET;
      acc_q        <= '0;
      drop_q       <= '0;
      peak_q       <= '0;
      stev_q       <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (chain_done) begin
        busy_q <= 1'b0;
      end
      if (chain_done) begin
        acc_q  <= acc_d;
        drop_q <= drop_d;
        peak_q <= peak_d;
        stev_q <= stev_d;
      end
      if (out_take || !out_valid_q) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q <= chain_done;
        end
      end else if (chain_done) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      depth_q <= in_data_i.depth_level;
    end
    if (out_take || !out_valid_q) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (chain_done) begin
        out_q <= res;
      end
    end else if (chain_done) begin
      pend_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Only one command is ever in flight along the chain.
  a_one_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one packet in the cell chain");

  // A packet leaving the chain belongs to an accepted command.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |-> busy_q)
    else $error("chain produced a result with no command in flight");

  // The holding register fills only behind a stalled output register.
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("holding register full while output register empty");

  // An accepted command shows up in the first cell on the next cycle.
  a_enter_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> chain_vld[0])
    else $error("accepted command did not enter the chain");

  // A bad sensor id never reports entry data.
  a_bad_id_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_BAD_ID) |->
      (!out_q.entry_seen && !out_q.entry_stale && out_q.entry_sequence == 32'd0))
    else $error("invalid sensor id result carries entry data");

endmodule
